FILE: rtl/core/trsc_pkg.sv
// ----------------------------------------------------------------------------
// trsc_pkg
// Shared types and codes for the timed relay switch controller.
// ----------------------------------------------------------------------------
`default_nettype none

package trsc_pkg;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned ElapsedW = 16;
  localparam int unsigned TimerW   = 32;
  localparam int unsigned PaddrW   = 4;
  localparam int unsigned PdataW   = 32;

  // item commands
  localparam logic [CmdW-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CmdW-1:0] CMD_ON     = 2'd1;
  localparam logic [CmdW-1:0] CMD_OFF    = 2'd2;

  // register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_TOGGLE_MODE = 2'd0;
  localparam logic [1:0] REG_ON_TIME     = 2'd1;
  localparam logic [1:0] REG_OFF_TIME    = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0]     cmd;
    logic                level;
    logic [ElapsedW-1:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic relay_on;
    logic changed;
  } out_item_t;

  typedef struct packed {
    logic              toggle_mode;
    logic [TimerW-1:0] on_time_ms;
    logic [TimerW-1:0] off_time_ms;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/trsc_regs.sv
// ----------------------------------------------------------------------------
// trsc_regs
// APB-style configuration registers: mode, auto-off and re-on delays.
// ----------------------------------------------------------------------------
`default_nettype none

module trsc_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [trsc_pkg::PaddrW-1:0]   cfg_paddr,
  input  wire logic [trsc_pkg::PdataW-1:0]   cfg_pwdata,
  output logic      [trsc_pkg::PdataW-1:0]   cfg_prdata,
  output logic                               cfg_pready,
  output trsc_pkg::cfg_t                     cfg
);

  trsc_pkg::cfg_t cfg_r;
  trsc_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        trsc_pkg::REG_TOGGLE_MODE: cfg_nxt.toggle_mode = cfg_pwdata[0];
        trsc_pkg::REG_ON_TIME:     cfg_nxt.on_time_ms  = cfg_pwdata;
        trsc_pkg::REG_OFF_TIME:    cfg_nxt.off_time_ms = cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      trsc_pkg::REG_TOGGLE_MODE: cfg_prdata = {{(trsc_pkg::PdataW-1){1'b0}}, cfg_r.toggle_mode};
      trsc_pkg::REG_ON_TIME:     cfg_prdata = cfg_r.on_time_ms;
      trsc_pkg::REG_OFF_TIME:    cfg_prdata = cfg_r.off_time_ms;
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: rtl/core/trsc_step.sv
// ----------------------------------------------------------------------------
// trsc_step
// Relay state and per-item next-state logic: timer, edge detect, mode rules.
// ----------------------------------------------------------------------------
`default_nettype none

module trsc_step (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_en,
  input  wire trsc_pkg::in_item_t item,
  input  wire trsc_pkg::cfg_t     cfg,
  output trsc_pkg::out_item_t     result
);

  logic                        lvl_r, lvl_nxt;
  logic                        prev_in_r, prev_in_nxt;
  logic [trsc_pkg::TimerW-1:0] timer_r, timer_nxt;
  logic                        pend_on_r, pend_on_nxt;
  logic                        pend_off_r, pend_off_nxt;

  logic [trsc_pkg::TimerW:0]   sum;
  logic [trsc_pkg::TimerW-1:0] tmr;
  logic                        rise, fall, timed, on_expired, off_expired, forced;

  // saturating timer advance
  assign sum = {1'b0, timer_r} + {{(trsc_pkg::TimerW+1-trsc_pkg::ElapsedW){1'b0}},
                                  item.elapsed_ms};
  assign tmr = sum[trsc_pkg::TimerW] ? '1 : sum[trsc_pkg::TimerW-1:0];

  assign rise        = item.level & ~prev_in_r;
  assign fall        = ~item.level & prev_in_r;
  assign timed       = ~cfg.toggle_mode & (cfg.on_time_ms != '0);
  assign on_expired  = (cfg.on_time_ms != '0) & (tmr > cfg.on_time_ms);
  assign off_expired = tmr > cfg.off_time_ms;

  always_comb begin
    lvl_nxt      = lvl_r;
    prev_in_nxt  = prev_in_r;
    timer_nxt    = tmr;
    pend_on_nxt  = pend_on_r;
    pend_off_nxt = pend_off_r;
    forced       = 1'b0;
    case (item.cmd)
      trsc_pkg::CMD_ON:  pend_on_nxt  = 1'b1;
      trsc_pkg::CMD_OFF: pend_off_nxt = 1'b1;
      trsc_pkg::CMD_SAMPLE: begin
        if (!lvl_r) begin
          if (pend_on_r) begin
            pend_on_nxt = 1'b0;
            lvl_nxt     = 1'b1;
            forced      = 1'b1;
          end else if (rise || (timed && item.level && off_expired)) begin
            lvl_nxt = 1'b1;
          end
        end else begin
          if (pend_off_r) begin
            pend_off_nxt = 1'b0;
            lvl_nxt      = 1'b0;
            forced       = 1'b1;
          end else if (cfg.toggle_mode) begin
            if (rise || on_expired) lvl_nxt = 1'b0;
          end else begin
            if (fall || on_expired) lvl_nxt = 1'b0;
          end
        end
        // a forced change leaves the edge detector alone
        if (!forced) prev_in_nxt = item.level;
      end
      default: ;
    endcase
    if (lvl_nxt != lvl_r) timer_nxt = '0;
  end

  assign result.relay_on = lvl_nxt;
  assign result.changed  = lvl_nxt ^ lvl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r      <= 1'b0;
      prev_in_r  <= 1'b0;
      timer_r    <= '0;
      pend_on_r  <= 1'b0;
      pend_off_r <= 1'b0;
    end else if (step_en) begin
      lvl_r      <= lvl_nxt;
      prev_in_r  <= prev_in_nxt;
      timer_r    <= timer_nxt;
      pend_on_r  <= pend_on_nxt;
      pend_off_r <= pend_off_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/timed_relay_switch_controller.sv
// ----------------------------------------------------------------------------
// timed_relay_switch_controller
// Relay driver from a switch input: toggle, follow and timed follow modes.
// ----------------------------------------------------------------------------
//  channel  ports                          payload / width
//  in       in_valid, in_ready, in_data    in_item_t: cmd 2, level 1, elapsed_ms 16
//  out      out_valid, out_ready, out_data out_item_t: relay_on 1, changed 1
//  cfg      cfg_psel .. cfg_pready         APB, 32-bit data, regs at 0x0/0x4/0x8
//
//  One item per cycle while the result is not stalled; input register, then result register.
//  The relay state updates in the single cycle an item moves from the input
//  register to the result register, so the next item sees it at once.
//  A stalled result holds the input register; in_ready then drops.
//  Synchronous reset clears relay state, pending flags, timer and registers.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_relay_switch_controller (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire trsc_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output trsc_pkg::out_item_t                out_data,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [trsc_pkg::PaddrW-1:0]   cfg_paddr,
  input  wire logic [trsc_pkg::PdataW-1:0]   cfg_pwdata,
  output logic      [trsc_pkg::PdataW-1:0]   cfg_prdata,
  output logic                               cfg_pready
);

  trsc_pkg::cfg_t      cfg;
  trsc_pkg::in_item_t  s1_item_r;
  logic                s1_valid_r, s1_valid_nxt;
  trsc_pkg::out_item_t out_data_r;
  logic                out_valid_r, out_valid_nxt;
  trsc_pkg::out_item_t step_out;
  logic                advance;

  trsc_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  trsc_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(advance),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (step_out)
  );

  assign advance  = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | advance;

  assign s1_valid_nxt  = (in_valid & in_ready) | (s1_valid_r & ~advance);
  assign out_valid_nxt = advance | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_item_r <= in_data;
    if (advance) out_data_r <= step_out;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // changed flag agrees with the level reported by the previous item
  a_changed_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    advance && out_valid_r |->
      (step_out.changed == (step_out.relay_on != out_data_r.relay_on)))
    else $error("changed flag disagrees with relay level history");

  // remote requests and unused codes never switch the relay
  a_no_change_on_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (s1_item_r.cmd != trsc_pkg::CMD_SAMPLE) |-> !step_out.changed)
    else $error("relay switched on a non-sample item");

  // a full input register behind a stalled result blocks new items
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("item accepted while pipeline is full");

  // an accepted item always lands in the input register
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r)
    else $error("accepted item lost");

endmodule

`default_nettype wire
